// ----- rtl/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

  // token kinds on the input side
  localparam logic [3:0] CMD_NUMBER = 4'd0;
  localparam logic [3:0] CMD_NAME   = 4'd1;
  localparam logic [3:0] CMD_FUNC   = 4'd2;
  localparam logic [3:0] CMD_PLUS   = 4'd3;
  localparam logic [3:0] CMD_MINUS  = 4'd4;
  localparam logic [3:0] CMD_MUL    = 4'd5;
  localparam logic [3:0] CMD_DIV    = 4'd6;
  localparam logic [3:0] CMD_POW    = 4'd7;
  localparam logic [3:0] CMD_SQRT   = 4'd8;
  localparam logic [3:0] CMD_OPEN   = 4'd9;
  localparam logic [3:0] CMD_CLOSE  = 4'd10;
  localparam logic [3:0] CMD_END    = 4'd11;

  // result kinds beyond the shared codes
  localparam logic [3:0] KIND_UMINUS = 4'd9;
  localparam logic [3:0] KIND_END    = 4'd10;
  // open bracket as it sits on the stack
  localparam logic [3:0] KIND_OPEN   = 4'd11;

  // error codes
  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW       = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED_CLOSE = 2'd2;
  localparam logic [1:0] ERR_UNMATCHED_OPEN  = 2'd3;

  // stack entry: function id in bit 4, kind in bits 3..0
  localparam int ENTRY_W = 5;
  localparam int STACK_DEPTH_DEF = 32;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [1:0]  err;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_OP_POP,
    ST_CLOSE_POP,
    ST_END_POP,
    ST_END_EMIT,
    ST_ERR
  } state_t;

  // operator priority, open bracket lowest
  function automatic logic [2:0] prio(input logic [3:0] kind);
    logic [2:0] p;
    case (kind)
      CMD_FUNC:               p = 3'd5;
      CMD_PLUS, CMD_MINUS:    p = 3'd1;
      CMD_MUL, CMD_DIV:       p = 3'd2;
      CMD_POW, CMD_SQRT:      p = 3'd3;
      KIND_UMINUS:            p = 3'd4;
      default:                p = 3'd0;
    endcase
    return p;
  endfunction

  // result built from a popped stack entry
  function automatic result_t entry_result(input logic [ENTRY_W-1:0] e);
    result_t r;
    r.kind  = e[3:0];
    r.value = (e[3:0] == CMD_FUNC) ? {31'd0, e[4]} : 32'd0;
    r.err   = ERR_NONE;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itp_stack_ram.sv -----
`default_nettype none

module itp_stack_ram
  import itp_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int WIDTH = ENTRY_W
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itp_out_reg.sv -----
`default_nettype none

module itp_out_reg
  import itp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire result_t     res,
  output logic             space,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // out_value
  output logic [5:0]       m_tuser,  // out_kind [3:0], error_code [5:4]
  output logic             m_tlast   // last_of_run
);

  logic    valid;
  result_t held;

  // room when empty or when the waiting result leaves this cycle
  assign space = !valid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (space && push) begin
      held <= res;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = held.value;
  assign m_tuser  = {held.err, held.kind};
  assign m_tlast  = held.last;

endmodule

`default_nettype wire

// ----- rtl/infix_to_postfix_converter.sv -----
`default_nettype none

// Infix to postfix token converter (shunting yard).
// Input channel s_*: one token per transfer, token kind on s_tuser, number
// value, name id or function id on s_tdata. Output channel m_*: postfix
// results, value on m_tdata, kind and error code on m_tuser, m_tlast on the
// end marker that closes an expression.
// Operators wait on a stack held in a synchronous RAM; the controller reads
// the top entry, decides, and pops one entry per cycle while the output has room.
// With a ready receiver, a number, a name, an unused code, an open
// bracket, or an operator pushed onto an empty stack is handled straight
// from idle. Any other operator first pops the entries that bind at least
// as tightly and is then pushed; a close bracket pops down to its open
// bracket and drops it; the end token pops the whole stack, then sends the
// end marker. Each pop is one RAM read on the single read port. An error
// is sent as an error result of its own.
// Results pass through one output register, so the next token is taken
// while a result still waits. When the receiver stalls, popping waits with
// the RAM read re-issued; s_tready is low until the current token is done.
// Reset (rst, synchronous) empties the stack, drops any waiting result and
// makes the next minus unary; no clearing pass over the RAM is needed.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // in_value
  input  wire logic [3:0]  s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_value
  output logic [5:0]       m_tuser,   // out_kind [3:0], error_code [5:4]
  output logic             m_tlast    // last_of_run
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t       state, state_next;
  logic [CW-1:0] count, count_next;
  logic          opexp, opexp_next;
  logic [3:0]    tok_kind, tok_kind_next;
  logic [31:0]   tok_val, tok_val_next;
  logic [1:0]    err_code, err_code_next;
  logic          open_left, open_left_next;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;
  logic               emit, space;
  result_t            res;

  logic [CW-1:0]      cnt_m1, cnt_m2;
  logic               is_full;
  logic [3:0]         in_kind;
  logic [ENTRY_W-1:0] in_entry, tok_entry;

  assign cnt_m1  = count - CW'(1);
  assign cnt_m2  = count - CW'(2);
  assign is_full = (count == CW'(STACK_DEPTH));

  // kind of an incoming operator, minus turns unary where an operand is due
  assign in_kind  = (s_tuser == CMD_MINUS && opexp) ? KIND_UMINUS : s_tuser;
  assign in_entry = {(in_kind == CMD_FUNC) & s_tdata[0], in_kind};
  assign tok_entry = {(tok_kind == CMD_FUNC) & tok_val[0], tok_kind};

  itp_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  itp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (emit),
    .res      (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      opexp     <= 1'b1;
      open_left <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      opexp     <= opexp_next;
      open_left <= open_left_next;
    end
  end

  // token registers
  always_ff @(posedge clk) begin
    tok_kind <= tok_kind_next;
    tok_val  <= tok_val_next;
    err_code <= err_code_next;
  end

  // next state, stack access and results
  always_comb begin
    state_next     = state;
    count_next     = count;
    opexp_next     = opexp;
    tok_kind_next  = tok_kind;
    tok_val_next   = tok_val;
    err_code_next  = err_code;
    open_left_next = open_left;
    s_tready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = cnt_m1[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count[AW-1:0];
    wr_data        = tok_entry;
    emit           = 1'b0;
    res            = entry_result(rd_data);

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          tok_val_next = s_tdata;
          case (s_tuser) inside
            [CMD_NUMBER:CMD_NAME]: begin
              opexp_next    = 1'b0;
              tok_kind_next = s_tuser;
              res           = '{kind: s_tuser, value: s_tdata, err: ERR_NONE, last: 1'b0};
              if (space) begin
                emit = 1'b1;
              end else begin
                state_next = ST_OPND;
              end
            end
            [CMD_FUNC:CMD_SQRT]: begin
              opexp_next    = 1'b0;
              tok_kind_next = in_kind;
              if (count != '0) begin
                rd_en      = 1'b1;
                state_next = ST_OP_POP;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = in_entry;
                count_next = CW'(1);
              end
            end
            CMD_OPEN: begin
              opexp_next = 1'b1;
              if (!is_full) begin
                wr_en      = 1'b1;
                wr_data    = {1'b0, KIND_OPEN};
                count_next = count + CW'(1);
              end else begin
                err_code_next = ERR_OVERFLOW;
                state_next    = ST_ERR;
              end
            end
            CMD_CLOSE: begin
              opexp_next = 1'b0;
              if (count != '0) begin
                rd_en      = 1'b1;
                state_next = ST_CLOSE_POP;
              end else begin
                err_code_next = ERR_UNMATCHED_CLOSE;
                state_next    = ST_ERR;
              end
            end
            CMD_END: begin
              opexp_next     = 1'b1;
              open_left_next = 1'b0;
              if (count != '0) begin
                rd_en      = 1'b1;
                state_next = ST_END_POP;
              end else begin
                state_next = ST_END_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_OPND: begin
        res = '{kind: tok_kind, value: tok_val, err: ERR_NONE, last: 1'b0};
        if (space) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      // pop while the top binds at least as tightly, then push, or flag an overflow when full
      ST_OP_POP: begin
        if (prio(rd_data[3:0]) >= prio(tok_kind)) begin
          if (space) begin
            emit = 1'b1;
            if (count == CW'(1)) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              state_next = ST_IDLE;
            end else begin
              count_next = cnt_m1;
              rd_en      = 1'b1;
              rd_addr    = cnt_m2[AW-1:0];
            end
          end else begin
            rd_en = 1'b1;
          end
        end else if (!is_full) begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          state_next = ST_IDLE;
        end else begin
          err_code_next = ERR_OVERFLOW;
          state_next    = ST_ERR;
        end
      end

      // pop down to the matching open bracket; an emptied stack flags an unmatched close
      ST_CLOSE_POP: begin
        if (rd_data[3:0] == KIND_OPEN) begin
          count_next = cnt_m1;
          state_next = ST_IDLE;
        end else if (space) begin
          emit       = 1'b1;
          count_next = cnt_m1;
          if (count == CW'(1)) begin
            err_code_next = ERR_UNMATCHED_CLOSE;
            state_next    = ST_ERR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[AW-1:0];
          end
        end else begin
          rd_en = 1'b1;
        end
      end

      // flush the whole stack, open brackets are dropped
      ST_END_POP: begin
        if (rd_data[3:0] == KIND_OPEN || space) begin
          if (rd_data[3:0] == KIND_OPEN) begin
            open_left_next = 1'b1;
          end else begin
            emit = 1'b1;
          end
          count_next = cnt_m1;
          if (count == CW'(1)) begin
            state_next = ST_END_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[AW-1:0];
          end
        end else begin
          rd_en = 1'b1;
        end
      end

      ST_END_EMIT: begin
        res = '{kind: KIND_END, value: 32'd0,
                err: open_left ? ERR_UNMATCHED_OPEN : ERR_NONE, last: 1'b1};
        if (space) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_ERR: begin
        res = '{kind: CMD_NUMBER, value: 32'd0, err: err_code, last: 1'b0};
        if (space) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // stack fill never goes past the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // pop states always have an entry to look at
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OP_POP || state == ST_CLOSE_POP || state == ST_END_POP)
    |-> count != '0)
    else $error("pop state with empty stack");

  // the end marker leaves an empty stack behind
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    (emit && space && res.last) |=> (count == '0 && opexp))
    else $error("stack not empty after end marker");

  // a result is only handed over when the output register has room
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> space)
    else $error("result dropped on a stalled output");

  // reset leaves the controller idle with an empty stack
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == ST_IDLE && count == '0 && !m_tvalid))
    else $error("controller not idle after reset");

endmodule

`default_nettype wire
